/* sv/ppgbr_pkg.sv */
// Shared types, register indexes and constants of the PPG beat and rate tracker.
package ppgbr_pkg;

  // Default values of the top-level parameters.
  localparam int DEF_RATE_DEPTH  = 8;
  localparam int DEF_SAMPLE_BITS = 18;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DC_COEF        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_MS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AC_GAIN_SHIFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BPM_MIN        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BPM_MAX        = 3'd5;

  // Register values after reset.
  localparam logic [15:0] RST_DC_COEF        = 16'd64225;
  localparam logic [15:0] RST_REFRACTORY_MS  = 16'd700;
  localparam logic [21:0] RST_BEAT_THRESHOLD = 22'd60;
  localparam logic [1:0]  RST_AC_GAIN_SHIFT  = 2'd2;
  localparam logic [7:0]  RST_BPM_MIN        = 8'd20;
  localparam logic [7:0]  RST_BPM_MAX        = 8'd255;

  // Input item kinds.
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Field and state widths.
  localparam int AC_W   = 22;
  localparam int AMP_W  = 22;
  localparam int BPM_W  = 16;
  localparam int MS_W   = 32;
  localparam int AC_MAX = 2097151;
  localparam int AC_MIN = -2097152;

  // Rate divider geometry; the rate numerator is 60000 ms times 256.
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
  localparam logic [DIV_NUM_W-1:0] RATE_NUM = 24'd15360000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick;
    logic capture;
    logic mul;
    logic lvl;
    logic ac;
    logic peak;
    logic div_start;
    logic ring_upd;
    logic bpm_rate;
    logic bpm_avg;
    logic out_load;
  } ppgbr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rate_go;
    logic div_busy;
    logic rate_in_range;
  } ppgbr_sts_t;

endpackage

/* sv/ppgbr_top.sv */
// Top level of the PPG beat and rate tracker.
//
// Input items arrive on in_valid_i/in_ready_o with kind_i and ir_sample_i.
// A tick item (kind 0) advances the millisecond counter in the cycle it is
// accepted and gives no result. A sample item (kind 1) gives one result on
// out_valid_o/out_ready_i: beat_o, ac_value_o, amplitude_o and bpm_q8_o.
// A sample without a rate update passes the multiply, level, AC, peak and
// output states before out_valid_o rises. A beat with a nonzero interval
// waits for the rate from a 24-step restoring divider; an in-range rate also
// updates the averaging ring and takes the mean by a constant multiply.
// One sample is processed at a time; the next item is accepted as soon as the
// previous one has been moved to the result register.
// The result register holds while the receiver stalls; a finished sample waits
// in the controller until the register is free, and meanwhile no item is taken.
// Reset clears the counters, tracker state and rate ring and loads the
// register defaults. Configuration writes on cfg_we_i take effect at once.
module ppg_beat_and_rate_tracker_top import ppgbr_pkg::*; #(
  parameter int RATE_DEPTH  = DEF_RATE_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   kind_i,
  input  logic [SAMPLE_BITS-1:0] ir_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   beat_o,
  output logic signed [AC_W-1:0] ac_value_o,
  output logic [AMP_W-1:0]       amplitude_o,
  output logic [BPM_W-1:0]       bpm_q8_o
);

  ppgbr_cmd_t cmd;
  ppgbr_sts_t sts;

  ppgbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppgbr_dp #(
    .RATE_DEPTH  (RATE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .ir_sample_i (ir_sample_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .beat_o      (beat_o),
    .ac_value_o  (ac_value_o),
    .amplitude_o (amplitude_o),
    .bpm_q8_o    (bpm_q8_o)
  );

  // An accepted sample occupies the block for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_SAMPLE) |=> !in_ready_o)
    else $error("sample item did not make the block busy");

  // Starting the divider always makes it busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");

  // The averaging ring only takes an in-range rate from an idle divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ring_upd |-> sts.rate_in_range && !sts.div_busy)
    else $error("ring updated with an invalid rate");

  // A result load is followed by a valid result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("loaded result not presented");

endmodule

/* sv/ppgbr_div.sv */
// Restoring divider for the beat rate, one quotient bit per cycle.
module ppgbr_div import ppgbr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] dividend_i,
  input  logic [DIV_DEN_W-1:0] divisor_i,
  output logic                 busy_o,
  output logic [DIV_NUM_W-1:0] quot_o
);

  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIV_CNT_W'(DIV_NUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Operands; the quotient bits replace the dividend bits as they shift out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      if (fits) begin
        rem_q <= DIV_DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[DIV_DEN_W-1:0];
      end
      num_q <= {num_q[DIV_NUM_W-2:0], fits};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = num_q;

endmodule

/* sv/ppgbr_dp.sv */
// Datapath: configuration, DC tracker, AC and peak logic, rate ring and result registers.
module ppgbr_dp import ppgbr_pkg::*; #(
  parameter int RATE_DEPTH  = DEF_RATE_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [SAMPLE_BITS-1:0] ir_sample_i,
  input  ppgbr_cmd_t             cmd_i,
  output ppgbr_sts_t             sts_o,
  output logic                   beat_o,
  output logic signed [AC_W-1:0] ac_value_o,
  output logic [AMP_W-1:0]       amplitude_o,
  output logic [BPM_W-1:0]       bpm_q8_o
);

  localparam int LVL_W  = SAMPLE_BITS + 16;
  localparam int DIFF_W = LVL_W + 1;
  localparam int PROD_W = DIFF_W + 17;
  localparam int STEP_W = PROD_W - 16;
  localparam int T_W    = DIFF_W - 16;
  localparam int EXT_W  = (SAMPLE_BITS + 4 > AC_W + 1) ? SAMPLE_BITS + 4 : AC_W + 1;
  localparam int PTR_W  = $clog2(RATE_DEPTH);
  localparam int SUM_W  = BPM_W + $clog2(RATE_DEPTH);
  localparam logic signed [EXT_W-1:0] AC_MAX_E = EXT_W'(AC_MAX);
  localparam logic signed [EXT_W-1:0] AC_MIN_E = EXT_W'(AC_MIN);
  // Mean by reciprocal: ceil(2^AVG_S / depth) gives the exact floor for every ring sum.
  localparam int AVG_S   = SUM_W + PTR_W;
  localparam int AVG_P_W = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] AVG_M =
    (SUM_W+1)'(((64'd1 << AVG_S) + 64'(RATE_DEPTH) - 64'd1) / 64'(RATE_DEPTH));

  // Configuration registers.
  logic [15:0] dc_coef_q;
  logic [15:0] refr_q;
  logic [21:0] thr_q;
  logic [1:0]  gain_q;
  logic [7:0]  bpm_min_q;
  logic [7:0]  bpm_max_q;

  // Tracker state.
  logic [MS_W-1:0]        ms_q;
  logic [LVL_W-1:0]       level_q;
  logic signed [AC_W-1:0] prev_q;
  logic signed [AC_W-1:0] prev2_q;
  logic [MS_W-1:0]        last_q;
  logic [AMP_W-1:0]       held_q;
  logic [BPM_W-1:0]       bpm_q;
  logic [PTR_W-1:0]       ptr_q;
  logic                   filled_q;
  logic [SUM_W-1:0]       sum_q;

  // Per-item working registers.
  logic [SAMPLE_BITS-1:0]   ir_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [AC_W-1:0]   ac_q;
  logic [MS_W-1:0]          since_q;
  logic                     beat_q;
  logic [BPM_W-1:0]         ring_rd_q;
  logic [BPM_W-1:0]         ring_mem [RATE_DEPTH];

  // Result registers.
  logic                   out_beat_q;
  logic signed [AC_W-1:0] out_ac_q;
  logic [AMP_W-1:0]       out_amp_q;
  logic [BPM_W-1:0]       out_bpm_q;

  // Combinational values.
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [STEP_W-1:0] step;
  logic signed [DIFF_W-1:0] adj;
  logic signed [T_W-1:0]    t;
  logic signed [EXT_W-1:0]  t_ext;
  logic signed [EXT_W-1:0]  sh;
  logic signed [AC_W-1:0]   ac_d;
  logic [MS_W-1:0]          since;
  logic                     peak;
  logic [AC_W:0]            amp_full;
  logic [AMP_W-1:0]         amp;
  logic                     beat_d;
  logic                     div_busy;
  logic [DIV_NUM_W-1:0]     quot;
  logic [BPM_W-1:0]         rate16;
  logic [BPM_W-1:0]         old_rate;
  logic [AVG_P_W-1:0]       avg_prod;
  logic [BPM_W-1:0]         avg;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_coef_q <= RST_DC_COEF;
      refr_q    <= RST_REFRACTORY_MS;
      thr_q     <= RST_BEAT_THRESHOLD;
      gain_q    <= RST_AC_GAIN_SHIFT;
      bpm_min_q <= RST_BPM_MIN;
      bpm_max_q <= RST_BPM_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DC_COEF:        dc_coef_q <= cfg_data_i[15:0];
        CFG_REFRACTORY_MS:  refr_q    <= cfg_data_i[15:0];
        CFG_BEAT_THRESHOLD: thr_q     <= cfg_data_i[21:0];
        CFG_AC_GAIN_SHIFT:  gain_q    <= cfg_data_i[1:0];
        CFG_BPM_MIN:        bpm_min_q <= cfg_data_i[7:0];
        CFG_BPM_MAX:        bpm_max_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sample minus level, used for the tracker update and again for the AC value.
  assign diff   = $signed({1'b0, ir_q, 16'b0}) - $signed({1'b0, level_q});
  assign prod_d = $signed({1'b0, dc_coef_q}) * diff;
  // Floor of the product over 65536.
  assign step   = prod_q[PROD_W-1:16];

  // Truncation toward zero: bias negative values before the arithmetic shift.
  assign adj   = diff + $signed({{(DIFF_W-16){1'b0}}, {16{diff[DIFF_W-1]}}});
  assign t     = adj[DIFF_W-1:16];
  assign t_ext = EXT_W'(t);
  assign sh    = t_ext <<< gain_q;

  // Saturate the scaled AC value to the output range.
  always_comb begin
    if (sh > AC_MAX_E) begin
      ac_d = AC_MAX_E[AC_W-1:0];
    end else if (sh < AC_MIN_E) begin
      ac_d = AC_MIN_E[AC_W-1:0];
    end else begin
      ac_d = sh[AC_W-1:0];
    end
  end

  // Peak test after the refractory time, and the beat threshold.
  assign since    = ms_q - last_q;
  assign peak     = (since >= MS_W'(refr_q)) && (prev_q > prev2_q) && (prev_q > ac_q);
  assign amp_full = {prev_q[AC_W-1], prev_q} - {ac_q[AC_W-1], ac_q};
  assign amp      = amp_full[AMP_W-1:0];
  assign beat_d   = peak && (amp > thr_q);

  // Rate divider: the fixed numerator over the beat interval.
  ppgbr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (RATE_NUM),
    .divisor_i  (since_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // Rate saturates to the Q8.8 range.
  assign rate16   = (quot[DIV_NUM_W-1:BPM_W] != '0) ? '1 : quot[BPM_W-1:0];
  assign old_rate = filled_q ? ring_rd_q : '0;

  // Mean of the ring from the running sum.
  assign avg_prod = AVG_P_W'(sum_q) * AVG_P_W'(AVG_M);
  assign avg      = avg_prod[AVG_S +: BPM_W];

  assign sts_o.rate_go       = beat_d && (since != '0);
  assign sts_o.div_busy      = div_busy;
  assign sts_o.rate_in_range = (rate16 < {bpm_max_q, 8'h00}) && (rate16 > {bpm_min_q, 8'h00});

  // Tracker state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q     <= '0;
      level_q  <= '0;
      prev_q   <= '0;
      prev2_q  <= '0;
      last_q   <= '0;
      held_q   <= '0;
      bpm_q    <= '0;
      ptr_q    <= '0;
      filled_q <= 1'b0;
      sum_q    <= '0;
    end else begin
      if (cmd_i.tick) begin
        ms_q <= ms_q + 1'b1;
      end
      if (cmd_i.lvl) begin
        level_q <= level_q + step[LVL_W-1:0];
      end
      if (cmd_i.peak) begin
        if (peak) begin
          held_q <= amp;
        end
        if (beat_d) begin
          last_q <= ms_q;
        end
        prev2_q <= prev_q;
        prev_q  <= ac_q;
      end
      if (cmd_i.ring_upd) begin
        sum_q <= sum_q - SUM_W'(old_rate) + SUM_W'(rate16);
        if (ptr_q == PTR_W'(RATE_DEPTH - 1)) begin
          ptr_q    <= '0;
          filled_q <= 1'b1;
        end else begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
      if (cmd_i.bpm_rate) begin
        bpm_q <= rate16;
      end else if (cmd_i.bpm_avg) begin
        bpm_q <= avg;
      end
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ir_q <= ir_sample_i;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.ac) begin
      ac_q <= ac_d;
    end
    if (cmd_i.peak) begin
      beat_q  <= beat_d;
      since_q <= since;
    end
  end

  // Rate ring memory with a registered read at the write pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_upd) begin
      ring_mem[ptr_q] <= rate16;
    end
    ring_rd_q <= ring_mem[ptr_q];
  end

  // Result registers hold while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_beat_q <= beat_q;
      out_ac_q   <= ac_q;
      out_amp_q  <= held_q;
      out_bpm_q  <= bpm_q;
    end
  end

  assign beat_o      = out_beat_q;
  assign ac_value_o  = out_ac_q;
  assign amplitude_o = out_amp_q;
  assign bpm_q8_o    = out_bpm_q;

endmodule

/* sv/ppgbr_ctrl.sv */
// Controller: sequences one item through the datapath and owns the handshakes.
module ppgbr_ctrl import ppgbr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       kind_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  ppgbr_sts_t sts_i,
  output ppgbr_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_MUL        = 4'd1;
  localparam logic [3:0] ST_LVL        = 4'd2;
  localparam logic [3:0] ST_AC         = 4'd3;
  localparam logic [3:0] ST_PEAK       = 4'd4;
  localparam logic [3:0] ST_RATE_START = 4'd5;
  localparam logic [3:0] ST_RATE_WAIT  = 4'd6;
  localparam logic [3:0] ST_RING       = 4'd7;
  localparam logic [3:0] ST_AVG        = 4'd8;
  localparam logic [3:0] ST_OUT        = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == KIND_SAMPLE) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_MUL;
          end else begin
            cmd_o.tick = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_LVL;
      end
      ST_LVL: begin
        cmd_o.lvl = 1'b1;
        state_d   = ST_AC;
      end
      ST_AC: begin
        cmd_o.ac = 1'b1;
        state_d  = ST_PEAK;
      end
      ST_PEAK: begin
        cmd_o.peak = 1'b1;
        state_d    = sts_i.rate_go ? ST_RATE_START : ST_OUT;
      end
      ST_RATE_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (!sts_i.div_busy) begin
          if (sts_i.rate_in_range) begin
            state_d = ST_RING;
          end else begin
            cmd_o.bpm_rate = 1'b1;
            state_d        = ST_OUT;
          end
        end
      end
      ST_RING: begin
        cmd_o.ring_upd = 1'b1;
        state_d        = ST_AVG;
      end
      ST_AVG: begin
        cmd_o.bpm_avg = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        // Load the result register once it is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid: set on load, cleared when the receiver takes the item.
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule
